@@ rtl/mrml_pkg.sv @@
// shared types and constants for the modbus rtu master link
package mrml_pkg;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_RXB   = 3'd1,
    CMD_TXRDY = 3'd2,
    CMD_LOAD  = 3'd3,
    CMD_SEND  = 3'd4,
    CMD_READ  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_OK      = 3'd1,
    ST_BAD     = 3'd2,
    ST_OVERRUN = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_REFUSED = 3'd5
  } status_t;

  localparam logic CFG_SILENCE = 1'b0;
  localparam logic CFG_REPLY   = 1'b1;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] SIL_RESET  = 16'd35;
  localparam logic [15:0] REP_RESET  = 16'd20000;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] target_address;
    logic [7:0] request_length;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_data;
    logic [2:0] status;
    logic [7:0] reply_length;
    logic [7:0] read_data;
  } rsp_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/mrml_if.sv @@
// valid/ready channel carrying one item
interface mrml_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/mrml_ram.sv @@
// generic single-port-write ram with registered read
module mrml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/modbus_rtu_master_link.sv @@
// modbus rtu master link: framing, crc-16, silence and reply timers
//
// in channel takes up to one command item per cycle: tick, rx byte, tx ready,
// load pdu byte, start send, read rx. every item gives exactly one result
// item on the out channel with tx byte, status, reply length and read data.
// stage one accepts the item, updates all control state and issues reads
// of the rx and tx byte memories; stage two forms the result from the
// registered read data and holds it in the output register.
// there are two register stages, stage two and the output register, and
// items flow back to back at one item per cycle unless the receiver stalls.
// the address byte of a received frame is kept in a register so the
// expiry check needs no memory read.
// when the receiver stalls, the output register holds and the input stage
// accepts only while stage two is empty or moving into the output register.
// config writes take effect the next cycle; the user must do them while
// idle, which the block does not enforce. synchronous reset clears modes,
// counters, crc and timers; memory contents stay undefined until written.
module modbus_rtu_master_link #(
  parameter int FRAME_MAX = 256,
  parameter int FRAME_MIN = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  mrml_if.sink        in_ch,
  mrml_if.source      out_ch
);
  import mrml_pkg::*;

  localparam int AW = $clog2(FRAME_MAX);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] FMAX   = CW'(FRAME_MAX);
  localparam logic [CW-1:0] PLMAX  = CW'(FRAME_MAX - 3);
  localparam logic [CW-1:0] FMIN   = CW'(FRAME_MIN);

  typedef enum logic [1:0] {RX_IDLE, RX_RCV, RX_ERR} rx_mode_t;
  typedef enum logic [1:0] {TX_IDLE, TX_XMIT, TX_WAIT} tx_mode_t;
  typedef enum logic [1:0] {TM_IDLE, TM_SIL, TM_REPLY} tm_mode_t;

  logic [15:0] sil_r, rep_r;
  rx_mode_t    rx_mode_r, rx_mode_nxt;
  tx_mode_t    tx_mode_r, tx_mode_nxt;
  tm_mode_t    tm_mode_r, tm_mode_nxt;
  logic [15:0] tm_cnt_r, tm_cnt_nxt;
  logic [CW-1:0] rx_cnt_r, rx_cnt_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;
  logic [7:0]  rx_addr_r, rx_addr_nxt;
  logic [CW-1:0] tx_pos_r, tx_pos_nxt;
  logic [CW-1:0] tx_tot_r, tx_tot_nxt;
  logic [15:0] tx_crc_r, tx_crc_nxt;
  logic [7:0]  exp_addr_r, exp_addr_nxt;

  // stage two control
  logic        s2_v_r;
  logic [1:0]  s2_sel_r, s2_sel_nxt;  // 0 none, 1 tx memory byte, 2 rx read, 3 held tx byte
  logic [7:0]  s2_byte_r, s2_byte_nxt;
  logic        s2_txv_r, s2_txv_nxt;
  logic [2:0]  s2_st_r, s2_st_nxt;
  logic [7:0]  s2_len_r, s2_len_nxt;
  logic [15:0] tx_crc_pend_r;

  rsp_t        out_r;
  logic        out_v_r;

  logic        acc, s2_adv;
  req_t        req;
  logic        rx_we, tx_we;
  logic [AW-1:0] rx_waddr, tx_waddr, rx_raddr, tx_raddr;
  logic [AW-1:0] rd_addr_r;
  logic [7:0]  rx_rdata, tx_rdata;

  assign req     = in_ch.data;
  assign s2_adv  = s2_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s2_v_r || s2_adv;
  assign acc     = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  mrml_ram #(.WIDTH(8), .DEPTH(FRAME_MAX)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_waddr), .wdata(req.data_byte),
    .raddr(rx_raddr), .rdata(rx_rdata));
  mrml_ram #(.WIDTH(8), .DEPTH(FRAME_MAX)) u_tx_ram (
    .clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(req.data_byte),
    .raddr(tx_raddr), .rdata(tx_rdata));

  logic [15:0]   limit, cnt_inc;
  logic [CW-1:0] plen;
  // the crc of the previous byte may still be pending on tx memory data
  logic [15:0]   tx_crc_cur;

  assign tx_crc_cur = (s2_v_r && s2_sel_r == 2'd1 && s2_txv_r) ?
                      crc_byte(tx_crc_pend_r, tx_rdata) : tx_crc_r;

  always_comb begin
    rx_mode_nxt  = rx_mode_r;
    tx_mode_nxt  = tx_mode_r;
    tm_mode_nxt  = tm_mode_r;
    tm_cnt_nxt   = tm_cnt_r;
    rx_cnt_nxt   = rx_cnt_r;
    rx_crc_nxt   = rx_crc_r;
    rx_addr_nxt  = rx_addr_r;
    tx_pos_nxt   = tx_pos_r;
    tx_tot_nxt   = tx_tot_r;
    tx_crc_nxt   = tx_crc_cur;
    exp_addr_nxt = exp_addr_r;
    s2_sel_nxt   = 2'd0;
    s2_byte_nxt  = 8'h00;
    s2_txv_nxt   = 1'b0;
    s2_st_nxt    = ST_NONE;
    s2_len_nxt   = 8'h00;
    rx_we        = 1'b0;
    tx_we        = 1'b0;
    rx_waddr     = rx_cnt_r[AW-1:0];
    tx_waddr     = req.byte_index[AW-1:0];
    // keep the read address while a read waits in stage two
    rx_raddr     = acc ? req.byte_index[AW-1:0] : rd_addr_r;
    tx_raddr     = AW'(tx_pos_r - CW'(1));
    limit        = (tm_mode_r == TM_SIL) ? sil_r : rep_r;
    cnt_inc      = tm_cnt_r + 16'd1;
    plen         = tx_tot_r - CW'(3);
    if (acc) begin
      unique case (req.command)
        CMD_TICK: begin
          if (tm_mode_r != TM_IDLE) begin
            if (cnt_inc >= limit) begin
              tm_mode_nxt = TM_IDLE;
              tm_cnt_nxt  = 16'd0;
              if (rx_mode_r == RX_RCV) begin
                rx_mode_nxt = RX_IDLE;
                if (rx_cnt_r >= FMIN && rx_crc_r == 16'd0 && rx_addr_r == exp_addr_r) begin
                  s2_st_nxt  = ST_OK;
                  s2_len_nxt = 8'(rx_cnt_r - CW'(3));
                end else begin
                  s2_st_nxt = ST_BAD;
                end
              end else if (rx_mode_r == RX_ERR) begin
                rx_mode_nxt = RX_IDLE;
                s2_st_nxt   = ST_OVERRUN;
              end else if (tx_mode_r == TX_WAIT) begin
                tx_mode_nxt = TX_IDLE;
                s2_st_nxt   = ST_TIMEOUT;
              end
            end else begin
              tm_cnt_nxt = cnt_inc;
            end
          end
        end
        CMD_RXB: begin
          if (rx_mode_r == RX_IDLE) begin
            rx_we       = 1'b1;
            rx_waddr    = '0;
            rx_addr_nxt = req.data_byte;
            rx_cnt_nxt  = CW'(1);
            rx_crc_nxt  = crc_byte(CRC_INIT, req.data_byte);
            rx_mode_nxt = RX_RCV;
            tx_mode_nxt = TX_IDLE;
          end else if (rx_mode_r == RX_RCV) begin
            if (rx_cnt_r < FMAX) begin
              rx_we      = 1'b1;
              rx_cnt_nxt = rx_cnt_r + CW'(1);
              rx_crc_nxt = crc_byte(rx_crc_r, req.data_byte);
            end else begin
              rx_mode_nxt = RX_ERR;
            end
          end
          tm_mode_nxt = TM_SIL;
          tm_cnt_nxt  = 16'd0;
        end
        CMD_TXRDY: begin
          if (tx_mode_r == TX_XMIT) begin
            if (tx_pos_r < tx_tot_r) begin
              s2_txv_nxt = 1'b1;
              if (tx_pos_r == '0) begin
                s2_byte_nxt = exp_addr_r;
                tx_crc_nxt  = crc_byte(tx_crc_cur, exp_addr_r);
              end else if (tx_pos_r <= plen) begin
                s2_sel_nxt = 2'd1;
              end else if (tx_pos_r == plen + CW'(1)) begin
                s2_byte_nxt = tx_crc_cur[7:0];
              end else begin
                s2_byte_nxt = tx_crc_cur[15:8];
              end
              tx_pos_nxt = tx_pos_r + CW'(1);
            end else begin
              tx_mode_nxt = TX_WAIT;
              tm_mode_nxt = TM_REPLY;
              tm_cnt_nxt  = 16'd0;
            end
          end
        end
        CMD_LOAD: begin
          tx_we = ({1'b0, req.byte_index} < 9'(PLMAX));
        end
        CMD_SEND: begin
          if (rx_mode_r != RX_IDLE) begin
            s2_st_nxt = ST_REFUSED;
          end else begin
            exp_addr_nxt = req.target_address;
            tx_tot_nxt   = (9'(req.request_length) > 9'(PLMAX)) ?
                           PLMAX + CW'(3) : CW'(req.request_length) + CW'(3);
            tx_pos_nxt   = '0;
            tx_crc_nxt   = CRC_INIT;
            tx_mode_nxt  = TX_XMIT;
          end
        end
        CMD_READ: begin
          if (9'(req.byte_index) < 9'(FMAX)) begin
            s2_sel_nxt = 2'd2;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sil_r      <= SIL_RESET;
      rep_r      <= REP_RESET;
      rx_mode_r  <= RX_IDLE;
      tx_mode_r  <= TX_IDLE;
      tm_mode_r  <= TM_IDLE;
      tm_cnt_r   <= '0;
      rx_cnt_r   <= '0;
      rx_crc_r   <= CRC_INIT;
      rx_addr_r  <= '0;
      tx_pos_r   <= '0;
      tx_tot_r   <= '0;
      tx_crc_r   <= CRC_INIT;
      exp_addr_r <= '0;
      s2_v_r     <= 1'b0;
      s2_sel_r   <= 2'd0;
      s2_txv_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_SILENCE) begin
        sil_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_REPLY) begin
        rep_r <= cfg_data;
      end
      rx_mode_r  <= rx_mode_nxt;
      tx_mode_r  <= tx_mode_nxt;
      tm_mode_r  <= tm_mode_nxt;
      tm_cnt_r   <= tm_cnt_nxt;
      rx_cnt_r   <= rx_cnt_nxt;
      rx_crc_r   <= rx_crc_nxt;
      rx_addr_r  <= rx_addr_nxt;
      tx_pos_r   <= tx_pos_nxt;
      tx_tot_r   <= tx_tot_nxt;
      exp_addr_r <= exp_addr_nxt;
      // crc of a memory byte is folded in the next cycle
      if (acc && s2_sel_nxt == 2'd1) begin
        tx_crc_r <= tx_crc_nxt;
      end else if (acc) begin
        tx_crc_r <= tx_crc_nxt;
      end else begin
        tx_crc_r <= tx_crc_cur;
      end
      if (acc) begin
        s2_v_r   <= 1'b1;
        s2_sel_r <= s2_sel_nxt;
        s2_txv_r <= s2_txv_nxt;
      end else if (s2_adv) begin
        s2_v_r   <= 1'b0;
        s2_sel_r <= 2'd0;
        s2_txv_r <= 1'b0;
      end else if (s2_v_r && s2_sel_r == 2'd1) begin
        s2_sel_r <= 2'd3;  // crc already folded, byte still held
      end
      if (s2_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  logic [7:0] hold_byte_r;
  always_ff @(posedge clk) begin
    rd_addr_r <= rx_raddr;
    if (acc) begin
      s2_byte_r     <= s2_byte_nxt;
      s2_st_r       <= s2_st_nxt;
      s2_len_r      <= s2_len_nxt;
      tx_crc_pend_r <= tx_crc_cur;
    end
    if (s2_v_r && s2_sel_r == 2'd1) begin
      hold_byte_r <= tx_rdata;
    end
    if (s2_adv) begin
      out_r.tx_valid     <= s2_txv_r;
      out_r.tx_data      <= (s2_sel_r == 2'd1) ? tx_rdata :
                            (s2_sel_r == 2'd3) ? hold_byte_r : s2_byte_r;
      out_r.status       <= s2_st_r;
      out_r.reply_length <= s2_len_r;
      out_r.read_data    <= (s2_sel_r == 2'd2) ? rx_rdata : 8'h00;
    end
  end

endmodule

@@ rtl/mrml_checker.sv @@
// port-level checks for the modbus rtu master link, bound to the top level
module mrml_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input mrml_pkg::rsp_t    out_data
);
  import mrml_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_txd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tx_valid |-> out_data.tx_data == 8'h00)
    else $error("tx byte without tx valid");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.reply_length == 8'h00)
    else $error("reply length without frame ok");

  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tx_valid |-> out_data.status == ST_NONE &&
    out_data.read_data == 8'h00)
    else $error("tx byte mixed with other result");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind modbus_rtu_master_link mrml_checker u_mrml_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));

@@ tb/modbus_rtu_master_link_chk.sv @@
`timescale 1ns / 100ps
// checker for the modbus rtu master link: predicts each result item and compares it
module modbus_rtu_master_link_chk
  import mrml_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  req_t        in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  rsp_t        out_item,
  output int          fail_count,
  output int          pending_count
);

  localparam int FMAX = 256;
  localparam int FMIN = 4;

  logic [15:0] sil_len, rep_len;
  logic [1:0]  rx_state, tx_state, tmr_state;
  logic [15:0] tmr_cnt;
  logic [7:0]  rx_bytes [FMAX];
  int          rx_len;
  logic [15:0] rx_sum;
  logic [7:0]  pdu_bytes [FMAX];
  int          tx_pos, tx_len;
  logic [15:0] tx_sum;
  logic [7:0]  dest_addr;
  rsp_t        expected_rsp [$];

  assign pending_count = expected_rsp.size();

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ 16'hA001;
      else c = c >> 1;
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic rsp_t predict_link(input req_t r);
    rsp_t o;
    logic [15:0] lim;
    int plen, rl;
    logic [7:0] b;
    o = '0;
    case (cmd_t'(r.command))
      CMD_TICK: begin
        if (tmr_state != 0) begin
          lim = (tmr_state == 1) ? sil_len : rep_len;
          if (32'(tmr_cnt) + 1 >= 32'(lim)) begin
            tmr_state = 0;
            tmr_cnt = 0;
            if (rx_state == 1) begin
              rx_state = 0;
              if (rx_len >= FMIN && rx_sum == 0 && rx_bytes[0] == dest_addr) begin
                o.status = ST_OK;
                o.reply_length = 8'(rx_len - 3);
              end else o.status = ST_BAD;
            end else if (rx_state == 2) begin
              rx_state = 0;
              o.status = ST_OVERRUN;
            end else if (tx_state == 2) begin
              tx_state = 0;
              o.status = ST_TIMEOUT;
            end
          end else tmr_cnt = tmr_cnt + 1;
        end
      end
      CMD_RXB: begin
        if (rx_state == 0) begin
          rx_bytes[0] = r.data_byte;
          rx_len = 1;
          rx_sum = crc16_step(16'hFFFF, r.data_byte);
          rx_state = 1;
          tx_state = 0;
        end else if (rx_state == 1) begin
          if (rx_len < FMAX) begin
            rx_bytes[rx_len] = r.data_byte;
            rx_len++;
            rx_sum = crc16_step(rx_sum, r.data_byte);
          end else rx_state = 2;
        end
        tmr_state = 1;
        tmr_cnt = 0;
      end
      CMD_TXRDY: begin
        if (tx_state == 1) begin
          if (tx_pos < tx_len) begin
            plen = tx_len - 3;
            if (tx_pos == 0) b = dest_addr;
            else if (tx_pos <= plen) b = pdu_bytes[tx_pos - 1];
            else if (tx_pos == plen + 1) b = tx_sum[7:0];
            else b = tx_sum[15:8];
            if (tx_pos <= plen) tx_sum = crc16_step(tx_sum, b);
            tx_pos++;
            o.tx_valid = 1'b1;
            o.tx_data = b;
          end else begin
            tx_state = 2;
            tmr_state = 2;
            tmr_cnt = 0;
          end
        end
      end
      CMD_LOAD: if (r.byte_index < FMAX - 3) pdu_bytes[r.byte_index] = r.data_byte;
      CMD_SEND: begin
        if (rx_state != 0) o.status = ST_REFUSED;
        else begin
          rl = r.request_length;
          if (rl > FMAX - 3) rl = FMAX - 3;
          dest_addr = r.target_address;
          tx_len = rl + 3;
          tx_pos = 0;
          tx_sum = 16'hFFFF;
          tx_state = 1;
        end
      end
      CMD_READ: if (r.byte_index < FMAX) o.read_data = rx_bytes[r.byte_index];
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      sil_len <= 16'd35;
      rep_len <= 16'd20000;
      rx_state = 0; tx_state = 0; tmr_state = 0; tmr_cnt = 0;
      rx_len = 0; rx_sum = 16'hFFFF; tx_pos = 0; tx_len = 0; tx_sum = 16'hFFFF;
      dest_addr = 0;
      expected_rsp.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SILENCE) sil_len <= cfg_data;
        else rep_len <= cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_rsp.size() == 0) report_mismatch("unexpected item", 1, 0);
        else begin
          want = expected_rsp.pop_front();
          if (out_item.tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", out_item.tx_valid, want.tx_valid);
          if (out_item.tx_data !== want.tx_data)
            report_mismatch("tx_data", out_item.tx_data, want.tx_data);
          if (out_item.status !== want.status)
            report_mismatch("status", out_item.status, want.status);
          if (out_item.reply_length !== want.reply_length)
            report_mismatch("reply_length", out_item.reply_length, want.reply_length);
          if (out_item.read_data !== want.read_data)
            report_mismatch("read_data", out_item.read_data, want.read_data);
        end
      end
      if (in_valid && in_ready) expected_rsp.push_back(predict_link(in_item));
    end
  end

endmodule

@@ tb/modbus_rtu_master_link_tb.sv @@
`timescale 1ns / 100ps
// top of the modbus rtu master link testbench: stimulus, idling and verdict
module modbus_rtu_master_link_tb;
  import mrml_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending_count;
  int          send_idle_pct, recv_idle_pct;
  longint      cycle_count = 0;
  logic [7:0]  rx_written_max;

  mrml_if #(.T(req_t)) in_ch ();
  mrml_if #(.T(rsp_t)) out_ch ();

  modbus_rtu_master_link dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  modbus_rtu_master_link_chk chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_item(in_ch.data), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_item(out_ch.data), .fail_count(fail_count), .pending_count(pending_count)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("modbus_rtu_master_link_tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input cmd_t c, input logic [7:0] d, input logic [7:0] idx,
                           input logic [7:0] addr, input logic [7:0] len);
    req_t r;
    r.command = c;
    r.data_byte = d;
    r.byte_index = idx;
    r.target_address = addr;
    r.request_length = len;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic ticks(input int n);
    repeat (n) send_item(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // sends a frame, a reply with good or broken crc or address and reads part back
  task automatic transaction(input logic [7:0] addr, input int plen, input int rlen,
                             input bit corrupt, input bit wrong_addr);
    logic [15:0] crc;
    logic [7:0]  b;
    for (int i = 0; i < plen; i++)
      send_item(CMD_LOAD, 8'($urandom), 8'(i), 8'($urandom), 8'($urandom));
    send_item(CMD_SEND, 8'($urandom), 8'($urandom), addr, 8'(plen));
    for (int i = 0; i < plen + 4; i++) begin
      send_item(CMD_TXRDY, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(9) == 0) ticks(1);
    end
    crc = 16'hFFFF;
    for (int i = 0; i < rlen + 1; i++) begin
      b = (i == 0) ? (wrong_addr ? addr ^ 8'h01 : addr) : 8'($urandom);
      crc = chk.crc16_step(crc, b);
      send_item(CMD_RXB, b, 8'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(7) == 0) ticks(1);
    end
    send_item(CMD_RXB, corrupt ? ~crc[7:0] : crc[7:0], 8'd0, 8'd0, 8'd0);
    send_item(CMD_RXB, crc[15:8], 8'd0, 8'd0, 8'd0);
    if (rx_written_max < 8'(rlen + 2)) rx_written_max = 8'(rlen + 2);
    ticks(6);
    for (int i = 0; i < 3; i++)
      send_item(CMD_READ, 8'($urandom), 8'($urandom_range(rx_written_max)),
                8'($urandom), 8'($urandom));
  endtask

  initial begin
    int n;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rx_written_max = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_reg(CFG_SILENCE, 16'd3);
    write_reg(CFG_REPLY, 16'd5);
    // fill the whole pdu store so every later send reads loaded bytes
    for (int i = 0; i < 253; i++)
      send_item(CMD_LOAD, 8'($urandom), 8'(i), 8'($urandom), 8'($urandom));
    // directed: unknown commands, out-of-range loads, refused send, timeout
    send_item(cmd_t'(3'd6), 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(cmd_t'(3'd7), 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_TXRDY, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_LOAD, 8'hAA, 8'd253, 8'h00, 8'h00);
    send_item(CMD_LOAD, 8'hFF, 8'd255, 8'hFF, 8'hFF);
    send_item(CMD_SEND, 8'h00, 8'h00, 8'hFF, 8'd0);
    repeat (4) send_item(CMD_TXRDY, 8'h00, 8'h00, 8'h00, 8'h00);
    ticks(5);
    transaction(8'h11, 2, 3, 1'b0, 1'b0);
    send_item(CMD_RXB, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_SEND, 8'h00, 8'h00, 8'h22, 8'd4);
    ticks(3);
    transaction(8'h00, 0, 0, 1'b0, 1'b0);
    transaction(8'hFF, 1, 2, 1'b1, 1'b0);
    transaction(8'h33, 1, 2, 1'b0, 1'b1);
    drain();

    // overrun with the largest frame and a saturated request
    for (int i = 0; i < 258; i++)
      send_item(CMD_RXB, 8'($urandom), 8'h00, 8'h00, 8'h00);
    rx_written_max = 8'd255;
    ticks(4);
    send_item(CMD_SEND, 8'h00, 8'h00, 8'h5A, 8'd255);
    for (int i = 0; i < 259; i++) send_item(CMD_TXRDY, 8'h00, 8'h00, 8'h00, 8'h00);
    ticks(6);
    send_item(CMD_READ, 8'h00, 8'd255, 8'h00, 8'h00);
    drain();
    write_reg(CFG_SILENCE, 16'd65535);
    write_reg(CFG_REPLY, 16'd1);
    transaction(8'h44, 1, 1, 1'b0, 1'b0);
    drain();
    write_reg(CFG_SILENCE, 16'd0);
    write_reg(CFG_REPLY, 16'd0);
    transaction(8'h45, 2, 2, 1'b0, 1'b0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 85 : 0;
      recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 6 : 0;
      write_reg(CFG_SILENCE, 16'($urandom_range(1, 4)));
      write_reg(CFG_REPLY, 16'($urandom_range(1, 8)));
      n = 0;
      while (n < 100) begin
        if ($urandom_range(9) < 8) begin
          transaction(8'($urandom), $urandom_range(0, 6), $urandom_range(0, 6),
                      $urandom_range(5) == 0, $urandom_range(7) == 0);
          n += 30;
        end else begin
          repeat (10) send_item(cmd_t'($urandom_range(7)), 8'($urandom),
                                8'($urandom_range(rx_written_max)), 8'($urandom),
                                8'($urandom));
          n += 10;
        end
      end
      drain();
    end
    write_reg(CFG_SILENCE, 16'd35);
    write_reg(CFG_REPLY, 16'd20000);
    drain();

    if (fail_count == 0) $display("modbus_rtu_master_link_tb OK");
    else $display("modbus_rtu_master_link_tb NOT OK");
    $finish;
  end

endmodule

@@ modbus_rtu_master_link.f @@
rtl/mrml_pkg.sv
rtl/mrml_if.sv
rtl/mrml_ram.sv
rtl/modbus_rtu_master_link.sv
rtl/mrml_checker.sv
tb/modbus_rtu_master_link_chk.sv
tb/modbus_rtu_master_link_tb.sv
